>>> hw/rtl/lsfe_pkg.sv
`timescale 1ns / 1ps

package lsfe_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_PIXELS  = 64;
    localparam int DEF_SWEEP_STEPS = 13;

    // field and register widths
    localparam int LED_COUNT_W = 7;
    localparam int COLOR_W     = 24;
    localparam int MODE_W      = 2;
    localparam int CCOUNT_W    = 2;
    localparam int PERIOD_W    = 16;
    localparam int INDEX_W     = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // phase hold lengths after the sweep ramp
    localparam int SWEEP_ON_HOLD  = 4;
    localparam int SWEEP_OFF_HOLD = 4;

    // n / 3 as (n * 171) >> 9, exact for n below 256
    localparam int THIRD_MUL   = 171;
    localparam int THIRD_SHIFT = 9;
    localparam int THIRD_PROD_W = LED_COUNT_W + 8;

    // fixed colors in wire order, green high
    localparam logic [COLOR_W-1:0] ORANGE_GRB = 24'h28A000;
    localparam logic [COLOR_W-1:0] RED_GRB    = 24'h00CC00;
    localparam logic [COLOR_W-1:0] OFF_GRB    = 24'h000000;

    // effect codes
    localparam logic [MODE_W-1:0] MODE_SOLID  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_THIRDS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SWEEP  = 2'd2;

    // color count codes with special meaning
    localparam logic [CCOUNT_W-1:0] CCOUNT_TWO   = 2'd2;
    localparam logic [CCOUNT_W-1:0] CCOUNT_THREE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COLOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COLOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT      = 3'd5;

    typedef struct packed {
        logic accept_tick;
        logic load_pixel;
    } lsfe_cmd_t;

    typedef struct packed {
        logic frame_start;
        logic last_pixel;
    } lsfe_status_t;

    // rgb packing (red high) to wire order (green high)
    function automatic logic [COLOR_W-1:0] to_grb(input logic [COLOR_W-1:0] rgb);
        return {rgb[15:8], rgb[23:16], rgb[7:0]};
    endfunction

endpackage

>>> hw/rtl/led_strip_effect_frame_engine_unit.sv
`timescale 1ns / 1ps

// led strip effect frame engine: each transfer on the input channel is one system
// tick. when the elapsed count reaches the frame interval register the frame phase
// steps (modulo SWEEP_STEPS + 9) and, unless the color count is three, a frame of
// led_count pixels (capped at MAX_PIXELS and at 127) follows on the output channel in
// grb wire order, one pixel per cycle while out_stall is low, frame_last marking the
// final one. in_stall stays high while the pixel counter walks the frame through the
// single output register, and out_stall on a pixel ahead of the last holds it there.
// ticks that fire no frame leave the block idle.
// effects: solid fill, blinking thirds (orange outer thirds on odd phases, red middle),
// and a sweep whose lit count is found per pixel by a running compare, not a divide.
// registers are to be written only while the block is idle; the block itself does
// not enforce this. writes to unused indexes are ignored.

module led_strip_effect_frame_engine_unit
    import lsfe_pkg::*;
#(
    parameter int MAX_PIXELS  = DEF_MAX_PIXELS,
    parameter int SWEEP_STEPS = DEF_SWEEP_STEPS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tick channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  restart,
    // pixel channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [INDEX_W-1:0]    pixel_index,
    output logic [COLOR_W-1:0]    pixel_grb,
    output logic                  frame_last
);

    lsfe_cmd_t    cmd;
    lsfe_status_t status;

    // sequencer: idle / emitting a frame, owns both handshakes
    lsfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // registers, tick counters, frame context and pixel generation
    lsfe_datapath #(
        .MAX_PIXELS  (MAX_PIXELS),
        .SWEEP_STEPS (SWEEP_STEPS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .restart     (restart),
        .cmd         (cmd),
        .status      (status),
        .pixel_index (pixel_index),
        .pixel_grb   (pixel_grb),
        .frame_last  (frame_last)
    );

    // pixels are only generated while ticks are held off
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_pixel |-> in_stall)
        else $error("pixel loaded while tick channel open");

    // a tick is never taken in the same cycle a pixel is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept_tick |-> !cmd.load_pixel)
        else $error("tick accepted during pixel load");

    // a pixel transfer that is not the last one happens mid-frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !frame_last) |-> in_stall)
        else $error("non-final pixel while idle");

    // a stalled pixel stays valid and keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pixel_index)
                                      && $stable(pixel_grb) && $stable(frame_last)))
        else $error("stalled pixel changed");

endmodule

>>> hw/rtl/lsfe_ctrl.sv
`timescale 1ns / 1ps

module lsfe_ctrl
    import lsfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  lsfe_status_t status,
    output lsfe_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        in_stall        = 1'b1;
        cmd.accept_tick = 1'b0;
        cmd.load_pixel  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall        = 1'b0;
                cmd.accept_tick = in_valid;
                if (in_valid && status.frame_start)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.load_pixel = slot_free;
                if (slot_free && status.last_pixel)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_pixel)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/lsfe_datapath.sv
`timescale 1ns / 1ps

module lsfe_datapath
    import lsfe_pkg::*;
#(
    parameter int MAX_PIXELS  = DEF_MAX_PIXELS,
    parameter int SWEEP_STEPS = DEF_SWEEP_STEPS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  restart,
    input  lsfe_cmd_t             cmd,
    output lsfe_status_t          status,
    output logic [INDEX_W-1:0]    pixel_index,
    output logic [COLOR_W-1:0]    pixel_grb,
    output logic                  frame_last
);

    localparam int PHASE_MOD = SWEEP_STEPS + SWEEP_ON_HOLD + SWEEP_OFF_HOLD + 1;
    localparam int PHASE_W   = $clog2(PHASE_MOD);
    localparam int PROD_W    = LED_COUNT_W + PHASE_W;
    localparam int N_CAP     = (MAX_PIXELS < (2 ** LED_COUNT_W) - 1) ?
                               MAX_PIXELS : (2 ** LED_COUNT_W) - 1;

    localparam logic [LED_COUNT_W-1:0] N_CAP_V      = N_CAP[LED_COUNT_W-1:0];
    localparam logic [PHASE_W-1:0]     PHASE_LAST   = PHASE_W'(PHASE_MOD - 1);
    localparam logic [PHASE_W-1:0]     SWEEP_END    = PHASE_W'(SWEEP_STEPS);
    localparam logic [PHASE_W-1:0]     HOLD_END     = PHASE_W'(SWEEP_STEPS + SWEEP_ON_HOLD);
    localparam logic [PROD_W-1:0]      STEP_V       = PROD_W'(SWEEP_STEPS);
    localparam logic [PERIOD_W-1:0]    ELAPSED_MAX  = '1;

    // configuration registers
    logic [MODE_W-1:0]      effect_mode_reg;
    logic [COLOR_W-1:0]     first_color_reg;
    logic [COLOR_W-1:0]     second_color_reg;
    logic [CCOUNT_W-1:0]    color_count_reg;
    logic [PERIOD_W-1:0]    frame_interval_reg;
    logic [LED_COUNT_W-1:0] led_count_reg;

    // tick state
    logic [PERIOD_W-1:0] elapsed_reg;
    logic [PERIOD_W-1:0] elapsed_next;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;

    // frame context
    logic [LED_COUNT_W-1:0] n_reg;
    logic [LED_COUNT_W-1:0] third_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [COLOR_W-1:0]     active_reg;
    logic                   odd_reg;
    logic                   sweep_part_reg;
    logic                   sweep_all_reg;

    // pixel walk
    logic [LED_COUNT_W-1:0] pix_reg;
    logic [PROD_W-1:0]      acc_reg;

    // output register
    logic [INDEX_W-1:0] index_reg;
    logic [COLOR_W-1:0] grb_reg;
    logic               last_reg;

    logic [PERIOD_W-1:0]     elapsed_base;
    logic [PERIOD_W-1:0]     elapsed_inc;
    logic [PHASE_W-1:0]      phase_base;
    logic                    fire;
    logic [LED_COUNT_W-1:0]  n_cur;
    logic [THIRD_PROD_W-1:0] third_prod;
    logic [LED_COUNT_W:0]    third_dbl;
    logic                    middle;
    logic                    lit;
    logic [COLOR_W-1:0]      pix_color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_mode_reg    <= MODE_SOLID;
            first_color_reg    <= '0;
            second_color_reg   <= '0;
            color_count_reg    <= CCOUNT_W'(1);
            frame_interval_reg <= PERIOD_W'(50);
            led_count_reg      <= LED_COUNT_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EFFECT_MODE:    effect_mode_reg    <= cfg_data[MODE_W-1:0];
                CFG_FIRST_COLOR:    first_color_reg    <= cfg_data[COLOR_W-1:0];
                CFG_SECOND_COLOR:   second_color_reg   <= cfg_data[COLOR_W-1:0];
                CFG_COLOR_COUNT:    color_count_reg    <= cfg_data[CCOUNT_W-1:0];
                CFG_FRAME_INTERVAL: frame_interval_reg <= cfg_data[PERIOD_W-1:0];
                CFG_LED_COUNT:      led_count_reg      <= cfg_data[LED_COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // tick bookkeeping
    always_comb
    begin
        elapsed_base = restart ? '0 : elapsed_reg;
        phase_base   = restart ? '0 : phase_reg;
        elapsed_inc  = (elapsed_base == ELAPSED_MAX) ? elapsed_base
                                                     : elapsed_base + PERIOD_W'(1);
        fire         = (elapsed_inc >= frame_interval_reg);
        elapsed_next = fire ? '0 : elapsed_inc;
        if (!fire)
        begin
            phase_next = phase_base;
        end
        else if (phase_base == PHASE_LAST)
        begin
            phase_next = '0;
        end
        else
        begin
            phase_next = phase_base + PHASE_W'(1);
        end
        n_cur      = (led_count_reg > N_CAP_V) ? N_CAP_V : led_count_reg;
        third_prod = THIRD_PROD_W'(n_cur) * THIRD_PROD_W'(THIRD_MUL);
    end

    assign status.frame_start = fire && (color_count_reg != CCOUNT_THREE) && (n_cur != '0);
    assign status.last_pixel  = (pix_reg == n_reg - LED_COUNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            phase_reg   <= '0;
        end
        else if (cmd.accept_tick)
        begin
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
        end
    end

    // frame context snapshot
    always_ff @(posedge clk)
    begin
        if (cmd.accept_tick)
        begin
            n_reg          <= n_cur;
            third_reg      <= LED_COUNT_W'(third_prod >> THIRD_SHIFT);
            prod_reg       <= PROD_W'(n_cur) * PROD_W'(phase_next);
            active_reg     <= to_grb((color_count_reg == CCOUNT_TWO && phase_next[0]) ?
                                     second_color_reg : first_color_reg);
            odd_reg        <= phase_next[0];
            sweep_part_reg <= (phase_next <= SWEEP_END);
            sweep_all_reg  <= (phase_next > SWEEP_END) && (phase_next < HOLD_END);
        end
    end

    // ramp: pixel i lit when (i+1)*steps <= n*phase
    always_comb
    begin
        third_dbl = {third_reg, 1'b0};
        middle    = (pix_reg >= third_reg) && ({1'b0, pix_reg} < third_dbl);
        lit       = sweep_part_reg ? (acc_reg <= prod_reg) : sweep_all_reg;
        case (effect_mode_reg)
            MODE_THIRDS: pix_color = middle ? RED_GRB : (odd_reg ? ORANGE_GRB : OFF_GRB);
            MODE_SWEEP:  pix_color = lit ? active_reg : OFF_GRB;
            default:     pix_color = active_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
            acc_reg <= '0;
        end
        else if (cmd.accept_tick)
        begin
            pix_reg <= '0;
            acc_reg <= STEP_V;
        end
        else if (cmd.load_pixel)
        begin
            pix_reg <= pix_reg + LED_COUNT_W'(1);
            acc_reg <= acc_reg + STEP_V;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            index_reg <= pix_reg[INDEX_W-1:0];
            grb_reg   <= pix_color;
            last_reg  <= status.last_pixel;
        end
    end

    assign pixel_index = index_reg;
    assign pixel_grb   = grb_reg;
    assign frame_last  = last_reg;

endmodule
